/* rtl/lgts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgts_pkg
// Shared widths, row types, opcodes and memory request types for the
// LDA Gibbs token sampler.
// ----------------------------------------------------------------------------
package lgts_pkg;

  localparam int TOPICS  = 8;
  localparam int TOPIC_W = $clog2(TOPICS);
  localparam int VOCAB   = 4096;
  localparam int WORD_W  = $clog2(VOCAB);
  localparam int DOCS    = 256;
  localparam int DOC_W   = $clog2(DOCS);

  localparam int CNT_W   = 16;
  localparam int TOT_W   = 24;
  localparam int WT_W    = 32;
  localparam int SUM_W   = 48;
  localparam int PRIOR_W = 24;
  localparam int VIU_W   = 13;
  localparam int FRAC_W  = 16;

  // datapath widths
  localparam int A_W   = CNT_W + FRAC_W + 1;        // doc count term
  localparam int B_W   = WT_W + 2;                  // word term
  localparam int BV_W  = PRIOR_W + VIU_W;           // beta * vocab
  localparam int DEN_W = SUM_W + 1;                 // denominator
  localparam int NUM_W = B_W + FRAC_W;              // b << 16
  localparam int Q_W   = 32;                        // saturated ratio
  localparam int RUN_W = A_W - FRAC_W + Q_W + 3;    // cumulative weight
  localparam int RND_W = 32;

  localparam int CFG_W   = PRIOR_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOCAB = 2'd2;

  localparam logic [PRIOR_W-1:0] ALPHA_RST = 24'd13107;
  localparam logic [PRIOR_W-1:0] BETA_RST  = 24'd32768;
  localparam logic [VIU_W-1:0]   VIU_RST   = 13'd4096;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_ADD      = 2'd1,
    OP_RESAMPLE = 2'd2,
    OP_CLEAR    = 2'd3
  } opcode_t;

  typedef logic [TOPICS-1:0][CNT_W-1:0] cnt_row_t;
  typedef logic [TOPICS-1:0][WT_W-1:0]  wt_row_t;

  typedef struct packed {
    logic [DOC_W-1:0]  doc_addr;
    logic [WORD_W-1:0] word_addr;
    logic              doc_we;
    logic              twc_we;
    logic              tw_we;
    cnt_row_t          doc_wdata;
    cnt_row_t          twc_wdata;
    wt_row_t           tw_wdata;
  } mem_req_t;

  typedef struct packed {
    cnt_row_t doc_rdata;
    cnt_row_t twc_rdata;
    wt_row_t  tw_rdata;
  } mem_rsp_t;

endpackage

/* rtl/lgts_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgts_mem
// Row memories: doc-topic counts per document, topic-word counts and trained
// weights per word. One row holds all topics; reads are registered.
// ----------------------------------------------------------------------------
module lgts_mem (
  input  logic              clk,
  input  lgts_pkg::mem_req_t req,
  output lgts_pkg::mem_rsp_t rsp
);
  import lgts_pkg::*;

  cnt_row_t doc_mem [DOCS];
  cnt_row_t twc_mem [VOCAB];
  wt_row_t  tw_mem  [VOCAB];

  cnt_row_t doc_rd_r;
  cnt_row_t twc_rd_r;
  wt_row_t  tw_rd_r;

  always_ff @(posedge clk) begin
    if (req.doc_we) begin
      doc_mem[req.doc_addr] <= req.doc_wdata;
    end
    doc_rd_r <= doc_mem[req.doc_addr];
  end

  always_ff @(posedge clk) begin
    if (req.twc_we) begin
      twc_mem[req.word_addr] <= req.twc_wdata;
    end
    twc_rd_r <= twc_mem[req.word_addr];
  end

  always_ff @(posedge clk) begin
    if (req.tw_we) begin
      tw_mem[req.word_addr] <= req.tw_wdata;
    end
    tw_rd_r <= tw_mem[req.word_addr];
  end

  assign rsp = {doc_rd_r, twc_rd_r, tw_rd_r};

endmodule

/* rtl/lgts_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgts_div
// Radix-2 restoring divider, 32 quotient bits, saturating at all ones.
// ----------------------------------------------------------------------------
module lgts_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lgts_pkg::NUM_W-1:0] num,
  input  logic [lgts_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [lgts_pkg::Q_W-1:0]   quot
);
  import lgts_pkg::*;

  localparam int CNT_BITS = $clog2(Q_W);
  localparam int HI_W = NUM_W - Q_W;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0]    rem_r, rem_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [Q_W-1:0]      lo_r, lo_nxt;
  logic [Q_W-1:0]      q_r, q_nxt;
  logic [DEN_W:0]      trial;
  logic                ge;

  assign trial = {rem_r, lo_r[Q_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    if (start) begin
      den_nxt = den;
      // quotient would not fit in 32 bits
      if (DEN_W'(num[NUM_W-1:Q_W]) >= den) begin
        q_nxt    = '1;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = DEN_W'(num[NUM_W-1:Q_W]);
        lo_nxt   = num[Q_W-1:0];
        cnt_nxt  = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      lo_nxt  = {lo_r[Q_W-2:0], 1'b0};
      q_nxt   = {q_r[Q_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_BITS'(Q_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

  // HI_W bits of the numerator enter the remainder at start
  initial_width_check : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (HI_W > 0 && !busy_r)) else $error("divider restarted while busy");

  done_is_pulse : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r || $past(start)) else $error("divider done held");

  busy_ends_done : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> done_r) else $error("divider stopped without done");

endmodule

/* rtl/lda_gibbs_token_sampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lda_gibbs_token_sampler
// Collapsed Gibbs topic sampler for one token: count store, per-topic ratio
// through a shared divider, cumulative draw and count update.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | opcode, doc_index, word, topic,
//          |           |                   | weight_value, random_word
//  out_    | output    | out_valid/out_stall | new_topic, used_fallback
//  cfg_    | input     | cfg_we            | cfg_index, cfg_wdata
//
//  Load goes from accept through S_PREP and S_MOD to S_WB, add also via
//  S_UPD; resample runs the 32-step divider for each topic with a nonzero
//  denominator, then a direct, fallback or scanned pick; clear zeroes one
//  count row per cycle. After reset a pass zeroes the memories, in_stall
//  high meanwhile and during a clear. One request in flight; the next is
//  taken while a finished result waits under out_stall.
// ----------------------------------------------------------------------------
module lda_gibbs_token_sampler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_opcode,
  input  logic [lgts_pkg::DOC_W-1:0]     in_doc_index,
  input  logic [lgts_pkg::WORD_W-1:0]    in_word,
  input  logic [lgts_pkg::TOPIC_W-1:0]   in_topic,
  input  logic [lgts_pkg::WT_W-1:0]      in_weight_value,
  input  logic [lgts_pkg::RND_W-1:0]     in_random_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lgts_pkg::TOPIC_W-1:0]   out_new_topic,
  output logic                           out_used_fallback,
  input  logic                           cfg_we,
  input  logic [lgts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lgts_pkg::CFG_W-1:0]     cfg_wdata
);
  import lgts_pkg::*;

  typedef enum logic [13:0] {
    S_SWEEP = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_PREP  = 14'b00000000000100,
    S_MOD   = 14'b00000000001000,
    S_DEN   = 14'b00000000010000,
    S_DIVGO = 14'b00000000100000,
    S_DIV   = 14'b00000001000000,
    S_MUL   = 14'b00000010000000,
    S_ACC   = 14'b00000100000000,
    S_SCALE = 14'b00001000000000,
    S_SEL   = 14'b00010000000000,
    S_PICK  = 14'b00100000000000,
    S_UPD   = 14'b01000000000000,
    S_WB    = 14'b10000000000000
  } state_t;

  // clear pass runs in S_IDLE, marked by kind X_CLR
  typedef enum logic [1:0] {
    X_NONE = 2'b01,
    X_CLR  = 2'b10
  } sweep_kind_t;

  state_t               state_r, state_nxt;
  sweep_kind_t          kind_r, kind_nxt;
  logic                 out_pend_r, out_pend_nxt;
  logic [WORD_W-1:0]    sweep_r, sweep_nxt;

  logic [PRIOR_W-1:0]   alpha_r, beta_r;
  logic [VIU_W-1:0]     viu_r;

  opcode_t              op_r, op_nxt;
  logic [DOC_W-1:0]     d_r, d_nxt;
  logic [WORD_W-1:0]    w_r, w_nxt;
  logic [TOPIC_W-1:0]   t_r, t_nxt;
  logic [WT_W-1:0]      val_r, val_nxt;
  logic [RND_W-1:0]     rnd_r, rnd_nxt;

  cnt_row_t             dc_row_r, dc_row_nxt;
  cnt_row_t             wc_row_r, wc_row_nxt;
  wt_row_t              tw_row_r, tw_row_nxt;
  logic [TOPICS-1:0][TOT_W-1:0] tot_r, tot_nxt;
  logic [TOPICS-1:0][SUM_W-1:0] sum_r, sum_nxt;
  logic [TOPICS-1:0][RUN_W-1:0] cum_r, cum_nxt;

  logic [TOPIC_W-1:0]   k_r, k_nxt;
  logic [BV_W-1:0]      bv_r, bv_nxt;
  logic [A_W-1:0]       a_r, a_nxt;
  logic [B_W-1:0]       b_r, b_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [Q_W-1:0]       q_r, q_nxt;
  logic [A_W-FRAC_W+Q_W-1:0] phi_r, phi_nxt;
  logic [FRAC_W+Q_W-1:0] plo_r, plo_nxt;
  logic [RUN_W-1:0]     run_r, run_nxt;
  logic                 dir_v_r, dir_v_nxt;
  logic [TOPIC_W-1:0]   dir_k_r, dir_k_nxt;
  logic [RUN_W-20+RND_W-1:0] shi_r, shi_nxt;
  logic [2*RND_W-1:0]   slo_r, slo_nxt;
  logic [RUN_W:0]       sel_r, sel_nxt;
  logic [TOPIC_W-1:0]   res_r, res_nxt;
  logic                 fb_r, fb_nxt;

  logic [TOPIC_W-1:0]   o_topic_r, o_topic_nxt;
  logic                 o_fb_r, o_fb_nxt;

  logic                 in_acc;
  logic                 div_start, div_done;
  logic [Q_W-1:0]       div_quot;
  mem_req_t             mreq;
  mem_rsp_t             mrsp;

  logic [SUM_W-1:0]     ld_sub;
  logic [SUM_W:0]       ld_add;
  logic [RUN_W-1:0]     acc_wt;

  assign in_stall  = (state_r != S_IDLE) || (kind_r == X_CLR);
  assign in_acc    = in_valid && !in_stall;
  assign div_start = (state_r == S_DIVGO) && (den_r != '0);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST;
      beta_r  <= BETA_RST;
      viu_r   <= VIU_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA: alpha_r <= cfg_wdata;
        CFG_BETA:  beta_r  <= cfg_wdata;
        CFG_VOCAB: viu_r   <= cfg_wdata[VIU_W-1:0];
        default: ;
      endcase
    end
  end

  // memory request
  always_comb begin
    mreq = '0;
    if (state_r == S_SWEEP || kind_r == X_CLR) begin
      mreq.doc_addr  = sweep_r[DOC_W-1:0];
      mreq.word_addr = sweep_r;
      mreq.doc_we    = sweep_r < WORD_W'(DOCS);
      mreq.twc_we    = 1'b1;
      mreq.tw_we     = (state_r == S_SWEEP);
    end else if (state_r == S_IDLE) begin
      mreq.doc_addr  = in_doc_index;
      mreq.word_addr = in_word;
    end else begin
      mreq.doc_addr  = d_r;
      mreq.word_addr = w_r;
      if (state_r == S_WB) begin
        mreq.doc_we  = (op_r == OP_ADD) || (op_r == OP_RESAMPLE);
        mreq.twc_we  = (op_r == OP_ADD) || (op_r == OP_RESAMPLE);
        mreq.tw_we   = (op_r == OP_LOAD);
      end
    end
    mreq.doc_wdata = (state_r == S_WB) ? dc_row_r : '0;
    mreq.twc_wdata = (state_r == S_WB) ? wc_row_r : '0;
    mreq.tw_wdata  = (state_r == S_WB) ? tw_row_r : '0;
  end

  lgts_mem u_mem (
    .clk (clk),
    .req (mreq),
    .rsp (mrsp)
  );

  lgts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({b_r, {FRAC_W{1'b0}}}),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign ld_sub = (sum_r[t_r] >= SUM_W'(tw_row_r[t_r])) ?
                  SUM_W'(sum_r[t_r] - SUM_W'(tw_row_r[t_r])) : '0;
  assign ld_add = {1'b0, ld_sub} + (SUM_W+1)'(val_r);
  assign acc_wt = RUN_W'(phi_r) + RUN_W'(plo_r[FRAC_W+Q_W-1:FRAC_W]);

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    sweep_nxt    = sweep_r;
    out_pend_nxt = out_pend_r;
    op_nxt  = op_r;  d_nxt = d_r;  w_nxt = w_r;  t_nxt = t_r;
    val_nxt = val_r; rnd_nxt = rnd_r;
    dc_row_nxt = dc_row_r; wc_row_nxt = wc_row_r; tw_row_nxt = tw_row_r;
    tot_nxt = tot_r; sum_nxt = sum_r; cum_nxt = cum_r;
    k_nxt = k_r; bv_nxt = bv_r; a_nxt = a_r; b_nxt = b_r; den_nxt = den_r;
    q_nxt = q_r; phi_nxt = phi_r; plo_nxt = plo_r; run_nxt = run_r;
    dir_v_nxt = dir_v_r; dir_k_nxt = dir_k_r;
    shi_nxt = shi_r; slo_nxt = slo_r; sel_nxt = sel_r;
    res_nxt = res_r; fb_nxt = fb_r;
    o_topic_nxt = o_topic_r; o_fb_nxt = o_fb_r;

    // result register drains independently
    if (out_pend_r && !out_stall) begin
      out_pend_nxt = 1'b0;
    end

    unique case (state_r)
      S_SWEEP: begin
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == WORD_W'(VOCAB - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (kind_r == X_CLR) begin
          sweep_nxt = sweep_r + 1'b1;
          if (sweep_r == WORD_W'(VOCAB - 1)) begin
            kind_nxt  = X_NONE;
            state_nxt = S_WB;
          end
        end else if (in_acc) begin
          op_nxt  = opcode_t'(in_opcode);
          d_nxt   = in_doc_index;
          w_nxt   = in_word;
          t_nxt   = in_topic;
          val_nxt = in_weight_value;
          rnd_nxt = in_random_word;
          res_nxt = in_topic;
          fb_nxt  = 1'b0;
          if (opcode_t'(in_opcode) == OP_CLEAR) begin
            kind_nxt  = X_CLR;
            sweep_nxt = '0;
            tot_nxt   = '0;
          end else begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        dc_row_nxt = mrsp.doc_rdata;
        wc_row_nxt = mrsp.twc_rdata;
        tw_row_nxt = mrsp.tw_rdata;
        state_nxt  = S_MOD;
      end
      S_MOD: begin
        unique case (op_r)
          OP_LOAD: begin
            sum_nxt[t_r]    = ld_add[SUM_W] ? '1 : ld_add[SUM_W-1:0];
            tw_row_nxt[t_r] = val_r;
            state_nxt       = S_WB;
          end
          OP_ADD: begin
            state_nxt = S_UPD;
          end
          default: begin
            if (dc_row_r[t_r] != '0) dc_row_nxt[t_r] = dc_row_r[t_r] - 1'b1;
            if (wc_row_r[t_r] != '0) wc_row_nxt[t_r] = wc_row_r[t_r] - 1'b1;
            if (tot_r[t_r] != '0)    tot_nxt[t_r]    = tot_r[t_r] - 1'b1;
            bv_nxt    = BV_W'(beta_r) * BV_W'(viu_r);
            k_nxt     = '0;
            run_nxt   = '0;
            dir_v_nxt = 1'b0;
            state_nxt = S_DEN;
          end
        endcase
      end
      S_DEN: begin
        a_nxt   = {1'b0, dc_row_r[k_r], {FRAC_W{1'b0}}} + A_W'(alpha_r);
        b_nxt   = B_W'(beta_r) + B_W'(tw_row_r[k_r]) +
                  B_W'({wc_row_r[k_r], {FRAC_W{1'b0}}});
        den_nxt = DEN_W'(bv_r) + DEN_W'(sum_r[k_r]) +
                  DEN_W'({tot_r[k_r], {FRAC_W{1'b0}}});
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        if (den_r == '0) begin
          // zero denominator: weight is zero, topic may be taken outright
          if (a_r != '0 && b_r != '0) begin
            dir_v_nxt = 1'b1;
            dir_k_nxt = k_r;
          end
          phi_nxt   = '0;
          plo_nxt   = '0;
          state_nxt = S_ACC;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          q_nxt     = div_quot;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        phi_nxt   = a_r[A_W-1:FRAC_W] * q_r;
        plo_nxt   = a_r[FRAC_W-1:0] * q_r;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        run_nxt      = run_r + acc_wt;
        cum_nxt[k_r] = run_nxt;
        if (k_r == TOPIC_W'(TOPICS - 1)) begin
          state_nxt = S_SCALE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_DEN;
        end
      end
      S_SCALE: begin
        if (dir_v_r) begin
          res_nxt   = dir_k_r;
          state_nxt = S_UPD;
        end else if (run_r == '0) begin
          res_nxt   = rnd_r[TOPIC_W-1:0];
          fb_nxt    = 1'b1;
          state_nxt = S_UPD;
        end else begin
          shi_nxt   = run_r[RUN_W-1:32] * rnd_r;
          slo_nxt   = run_r[31:0] * rnd_r;
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        sel_nxt   = (RUN_W+1)'(shi_r) + (RUN_W+1)'(slo_r[2*RND_W-1:RND_W]);
        k_nxt     = '0;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (k_r == TOPIC_W'(TOPICS - 1) || {1'b0, cum_r[k_r]} >= sel_r) begin
          res_nxt   = k_r;
          state_nxt = S_UPD;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_UPD: begin
        if (dc_row_r[res_r] != '1) dc_row_nxt[res_r] = dc_row_r[res_r] + 1'b1;
        if (wc_row_r[res_r] != '1) wc_row_nxt[res_r] = wc_row_r[res_r] + 1'b1;
        if (tot_r[res_r] != '1)    tot_nxt[res_r]    = tot_r[res_r] + 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        // writes land this cycle; result waits for a free output register
        if (!out_pend_r || !out_stall) begin
          out_pend_nxt = 1'b1;
          o_topic_nxt  = res_r;
          o_fb_nxt     = fb_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_SWEEP;
      kind_r     <= X_NONE;
      sweep_r    <= '0;
      out_pend_r <= 1'b0;
      tot_r      <= '0;
      sum_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      kind_r     <= kind_nxt;
      sweep_r    <= sweep_nxt;
      out_pend_r <= out_pend_nxt;
      tot_r      <= tot_nxt;
      sum_r      <= sum_nxt;
    end
    op_r <= op_nxt;  d_r <= d_nxt;  w_r <= w_nxt;  t_r <= t_nxt;
    val_r <= val_nxt; rnd_r <= rnd_nxt;
    dc_row_r <= dc_row_nxt; wc_row_r <= wc_row_nxt; tw_row_r <= tw_row_nxt;
    cum_r <= cum_nxt; k_r <= k_nxt; bv_r <= bv_nxt;
    a_r <= a_nxt; b_r <= b_nxt; den_r <= den_nxt; q_r <= q_nxt;
    phi_r <= phi_nxt; plo_r <= plo_nxt; run_r <= run_nxt;
    dir_v_r <= dir_v_nxt; dir_k_r <= dir_k_nxt;
    shi_r <= shi_nxt; slo_r <= slo_nxt; sel_r <= sel_nxt;
    res_r <= res_nxt; fb_r <= fb_nxt;
    o_topic_r <= o_topic_nxt; o_fb_r <= o_fb_nxt;
  end

  assign out_valid         = out_pend_r;
  assign out_new_topic     = o_topic_r;
  assign out_used_fallback = o_fb_r;

  accept_leaves_idle : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_PREP || kind_r == X_CLR))
    else $error("accepted request did not start");

  result_from_wb : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_pend_r) |-> $past(state_r) == S_WB)
    else $error("result raised outside write-back");

  div_only_in_div : assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside its wait state");

  fallback_only_resample : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB && fb_r) |-> op_r == OP_RESAMPLE)
    else $error("fallback flagged for a non-resample request");

endmodule

/* tb/sv/tb_lda_gibbs_token_sampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lda_gibbs_token_sampler
// Self-checking bench for the Gibbs token sampler: a directed table, then
// random load/add/resample/clear traffic over several prior settings, each
// result checked in arrival order vs behavioral topic predictor or typed row.
// ----------------------------------------------------------------------------
module tb_lda_gibbs_token_sampler;
  import lgts_pkg::*;

  typedef logic [63:0] u64_t;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int PHASE_ITEMS  = 330;
  localparam int DRAIN_CYCLES = 400;
  localparam int EXP_DEPTH    = 16;

  typedef struct {
    logic [TOPIC_W-1:0] topic;
    logic               fallback;
  } topic_result_t;

  typedef struct {
    opcode_t            op;
    logic [DOC_W-1:0]   doc;
    logic [WORD_W-1:0]  word;
    logic [TOPIC_W-1:0] topic;
    logic [WT_W-1:0]    weight;
    logic [RND_W-1:0]   rnd;
    bit                 typed;
    logic [TOPIC_W-1:0] exp_topic;
    logic               exp_fallback;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_opcode = '0;
  logic [DOC_W-1:0]     in_doc_index = '0;
  logic [WORD_W-1:0]    in_word = '0;
  logic [TOPIC_W-1:0]   in_topic = '0;
  logic [WT_W-1:0]      in_weight_value = '0;
  logic [RND_W-1:0]     in_random_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [TOPIC_W-1:0]   out_new_topic;
  logic                 out_used_fallback;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  lda_gibbs_token_sampler u_dut (.*);

  always #5 clk = ~clk;

  // model state
  logic [CNT_W-1:0]   doc_cnt [DOCS*TOPICS];
  logic [CNT_W-1:0]   word_cnt [TOPICS*VOCAB];
  logic [TOT_W-1:0]   tot_cnt [TOPICS];
  logic [WT_W-1:0]    tw_weight [TOPICS*VOCAB];
  logic [SUM_W-1:0]   tw_sum [TOPICS];
  logic [PRIOR_W-1:0] alpha_q = ALPHA_RST;
  logic [PRIOR_W-1:0] beta_q = BETA_RST;
  logic [VIU_W-1:0]   viu_q = VIU_RST;

  // expected results in acceptance order
  topic_result_t exp_fifo [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  int cycles = 0;
  int burst_left = 4;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic counts_down(int d, int w, int k);
    if (doc_cnt[d*TOPICS+k] != 0) doc_cnt[d*TOPICS+k]--;
    if (word_cnt[k*VOCAB+w] != 0) word_cnt[k*VOCAB+w]--;
    if (tot_cnt[k] != 0) tot_cnt[k]--;
  endtask

  task automatic counts_up(int d, int w, int k);
    if (doc_cnt[d*TOPICS+k] != '1) doc_cnt[d*TOPICS+k]++;
    if (word_cnt[k*VOCAB+w] != '1) word_cnt[k*VOCAB+w]++;
    if (tot_cnt[k] != '1) tot_cnt[k]++;
  endtask

  task automatic clear_counts();
    foreach (doc_cnt[i]) doc_cnt[i] = '0;
    foreach (word_cnt[i]) word_cnt[i] = '0;
    foreach (tot_cnt[i]) tot_cnt[i] = '0;
  endtask

  // Picks a topic: direct, fallback, or by cumulative weights of all topics.
  task automatic draw_topic(int d, int w, u64_t rnd, output topic_result_t res);
    u64_t a, b, den, r, wt, run, sel;
    u64_t cum [TOPICS];
    int direct;
    int k;
    run = 0;
    direct = -1;
    res.fallback = 1'b0;
    for (k = 0; k < TOPICS; k++) begin
      a = (u64_t'(doc_cnt[d*TOPICS+k]) << 16) + u64_t'(alpha_q);
      b = u64_t'(beta_q) + u64_t'(tw_weight[k*VOCAB+w]) + (u64_t'(word_cnt[k*VOCAB+w]) << 16);
      den = u64_t'(beta_q) * u64_t'(viu_q) + u64_t'(tw_sum[k]) + (u64_t'(tot_cnt[k]) << 16);
      wt = 0;
      if (den == 0) begin
        if (a != 0 && b != 0) direct = k;
      end else begin
        r = (b << 16) / den;
        if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
        wt = (a >> 16) * r + (((a & 64'hFFFF) * r) >> 16);
      end
      run += wt;
      cum[k] = run;
    end
    if (direct >= 0) begin
      res.topic = direct[TOPIC_W-1:0];
    end else if (run == 0) begin
      res.fallback = 1'b1;
      res.topic = rnd[TOPIC_W-1:0];
    end else begin
      sel = (run >> 32) * rnd + (((run & 64'hFFFF_FFFF) * rnd) >> 32);
      for (k = 0; k < TOPICS - 1; k++)
        if (cum[k] >= sel) break;
      res.topic = k[TOPIC_W-1:0];
    end
  endtask

  task automatic predict_topic(opcode_t op, int d, int w, int t, u64_t val, u64_t rnd,
                               output topic_result_t res);
    u64_t s;
    res.topic = t[TOPIC_W-1:0];
    res.fallback = 1'b0;
    case (op)
      OP_CLEAR: clear_counts();
      OP_LOAD: begin
        s = u64_t'(tw_sum[t]);
        s = (s >= u64_t'(tw_weight[t*VOCAB+w])) ? s - u64_t'(tw_weight[t*VOCAB+w]) : 0;
        s += val;
        if (s > 64'hFFFF_FFFF_FFFF) s = 64'hFFFF_FFFF_FFFF;
        tw_sum[t] = s[SUM_W-1:0];
        tw_weight[t*VOCAB+w] = val[WT_W-1:0];
      end
      OP_ADD: counts_up(d, w, t);
      default: begin
        counts_down(d, w, t);
        draw_topic(d, w, rnd, res);
        counts_up(d, w, res.topic);
      end
    endcase
  endtask

  // Drive one request from a falling edge; returns at a falling edge.
  task automatic send_request(dir_row_t row);
    topic_result_t res;
    in_opcode = row.op;
    in_doc_index = row.doc;
    in_word = row.word;
    in_topic = row.topic;
    in_weight_value = row.weight;
    in_random_word = row.rnd;
    in_valid = 1'b1;
    // in_stall only moves at rising edges, so the falling-edge value holds
    while (in_stall) @(negedge clk);
    @(posedge clk);
    predict_topic(row.op, row.doc, row.word, row.topic, row.weight, row.rnd, res);
    if (row.typed) begin
      res.topic = row.exp_topic;
      res.fallback = row.exp_fallback;
    end
    exp_fifo[exp_wr % EXP_DEPTH] = res;
    exp_wr++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (exp_wr != exp_rd) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_ALPHA: alpha_q = data;
      CFG_BETA:  beta_q = data;
      default:   viu_q = data[VIU_W-1:0];
    endcase
  endtask

  task automatic set_priors(logic [CFG_W-1:0] alpha, logic [CFG_W-1:0] beta,
                            logic [CFG_W-1:0] viu);
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_BETA, beta);
    write_reg(CFG_VOCAB, viu);
  endtask

  // directed requests; typed results are plain echoes or all-zero-weight draws
  dir_row_t dir_tbl [19] = '{
    '{OP_LOAD,     8'd0,   12'd0,    3'd0, 32'hFFFF_FFFF, 32'h0,         1, 3'd0, 1'b0},
    '{OP_LOAD,     8'd0,   12'd4095, 3'd7, 32'h0,         32'h0,         1, 3'd7, 1'b0},
    '{OP_LOAD,     8'd0,   12'd4095, 3'd7, 32'h1234_5678, 32'h0,         1, 3'd7, 1'b0},
    '{OP_LOAD,     8'd0,   12'd4095, 3'd7, 32'h1,         32'h0,         1, 3'd7, 1'b0},
    '{OP_RESAMPLE, 8'd0,   12'd5,    3'd3, 32'h0,         32'h0,         1, 3'd0, 1'b1},
    '{OP_RESAMPLE, 8'd1,   12'd4095, 3'd7, 32'h0,         32'hFFFF_FFFF, 1, 3'd7, 1'b1},
    '{OP_RESAMPLE, 8'd2,   12'd5,    3'd0, 32'h0,         32'h5,         1, 3'd5, 1'b1},
    '{OP_ADD,      8'd255, 12'd4095, 3'd7, 32'h0,         32'h0,         1, 3'd7, 1'b0},
    '{OP_ADD,      8'd255, 12'd0,    3'd0, 32'h0,         32'h0,         1, 3'd0, 1'b0},
    '{OP_RESAMPLE, 8'd255, 12'd4095, 3'd7, 32'h0,         32'h0,         0, 3'd0, 1'b0},
    '{OP_RESAMPLE, 8'd255, 12'd0,    3'd0, 32'h0,         32'hFFFF_FFFF, 0, 3'd0, 1'b0},
    '{OP_RESAMPLE, 8'd0,   12'd5,    3'd0, 32'h0,         32'h8000_0000, 0, 3'd0, 1'b0},
    '{OP_CLEAR,    8'd0,   12'd0,    3'd5, 32'h0,         32'h0,         1, 3'd5, 1'b0},
    '{OP_RESAMPLE, 8'd255, 12'd0,    3'd2, 32'h0,         32'h3,         1, 3'd3, 1'b1},
    '{OP_ADD,      8'd10,  12'd10,   3'd1, 32'h0,         32'h0,         1, 3'd1, 1'b0},
    '{OP_ADD,      8'd10,  12'd10,   3'd1, 32'h0,         32'h0,         1, 3'd1, 1'b0},
    '{OP_RESAMPLE, 8'd10,  12'd10,   3'd1, 32'h0,         32'h4000_0000, 0, 3'd0, 1'b0},
    '{OP_LOAD,     8'd0,   12'd10,   3'd4, 32'hFFFF_FFFF, 32'h0,         1, 3'd4, 1'b0},
    '{OP_RESAMPLE, 8'd10,  12'd10,   3'd4, 32'h0,         32'h9E37_79B9, 0, 3'd0, 1'b0}
  };

  // receiver stall: randomly switches between no, light and heavy stall
  int stall_mode = 0;
  always @(negedge clk) begin
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk) begin
    topic_result_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("lda_gibbs_token_sampler regression: fail");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (exp_wr == exp_rd) begin
        report_mismatch("unexpected result, topic", out_new_topic, -1);
      end else begin
        want = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_new_topic !== want.topic)
          report_mismatch("new_topic", out_new_topic, want.topic);
        if (out_used_fallback !== want.fallback)
          report_mismatch("used_fallback", out_used_fallback, want.fallback);
      end
    end
  end

  initial begin
    dir_row_t row;
    int pick;
    foreach (doc_cnt[i]) doc_cnt[i] = '0;
    foreach (word_cnt[i]) word_cnt[i] = '0;
    foreach (tot_cnt[i]) tot_cnt[i] = '0;
    foreach (tw_weight[i]) tw_weight[i] = '0;
    foreach (tw_sum[i]) tw_sum[i] = '0;

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    // memory clearing pass holds in_stall high
    do @(negedge clk); while (in_stall);

    // zero alpha makes an empty document draw fall back
    write_reg(CFG_ALPHA, '0);
    foreach (dir_tbl[i]) send_request(dir_tbl[i]);
    wait_idle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_priors(ALPHA_RST, BETA_RST, 24'd1);
        1: set_priors('0, '0, 24'd1);
        2: set_priors(24'hFF_FFFF, 24'hFF_FFFF, 24'd4096);
        default: set_priors(CFG_W'($urandom_range(0, 24'hFF_FFFF)),
                            CFG_W'($urandom_range(0, 24'h3_FFFF)),
                            CFG_W'($urandom_range(1, 4096)));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == PHASE_ITEMS / 2) wait_idle();
        pick = $urandom_range(0, 99);
        row.op = (pick < 12) ? OP_LOAD : (pick < 40) ? OP_ADD :
                 (pick < 99) ? OP_RESAMPLE : OP_CLEAR;
        // small doc/word pools so counts build up
        row.doc = ($urandom_range(0, 9) < 8) ? DOC_W'($urandom_range(0, 7)) :
                  DOC_W'($urandom);
        row.word = ($urandom_range(0, 9) < 8) ? WORD_W'($urandom_range(0, 15)) :
                   WORD_W'($urandom);
        row.topic = TOPIC_W'($urandom);
        row.weight = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h3_FFFF);
        row.rnd = $urandom;
        row.typed = 0;
        row.exp_topic = '0;
        row.exp_fallback = 1'b0;
        send_request(row);
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && exp_wr == exp_rd)
      $display("lda_gibbs_token_sampler regression: pass");
    else
      $display("lda_gibbs_token_sampler regression: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/lgts_pkg.sv
rtl/lgts_mem.sv
rtl/lgts_div.sv
rtl/lda_gibbs_token_sampler.sv
tb/sv/tb_lda_gibbs_token_sampler.sv
